// ===== sv/jbt_pkg.sv =====
// ============================================================================
// jbt_pkg
// Request types, token kind codes and keyword tables for the JSON byte lexer.
// ============================================================================
package jbt_pkg;

    // Input request: one text byte or the end-of-document marker
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_req;

    // Output request: one token byte or a status/error result
    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] value_byte;
        logic       byte_present;
        logic       token_first;
        logic       token_last;
        logic       parse_error;
        logic       document_done;
    } t_out_req;

    // Up to two results per input byte, handed from lexer to result queue
    typedef struct packed {
        logic [1:0] cnt;
        t_out_req   res0;
        t_out_req   res1;
    } t_push;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Token kinds
    localparam logic [3:0] KIND_STRING    = 4'd0;
    localparam logic [3:0] KIND_NUMBER    = 4'd1;
    localparam logic [3:0] KIND_BOOL      = 4'd2;
    localparam logic [3:0] KIND_NULL      = 4'd3;
    localparam logic [3:0] KIND_COMMA     = 4'd4;
    localparam logic [3:0] KIND_COLON     = 4'd5;
    localparam logic [3:0] KIND_BRACE_O   = 4'd6;
    localparam logic [3:0] KIND_BRACE_C   = 4'd7;
    localparam logic [3:0] KIND_BRACKET_O = 4'd8;
    localparam logic [3:0] KIND_BRACKET_C = 4'd9;

    // Keyword ids
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // Characters
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;

    // Keyword spelling, id clamped to 0..2 by caller
    function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (id)
            KW_TRUE: begin
                case (pos)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (pos)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] id);
        return (id == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic t_out_req jbt_res(input logic [3:0] kind, input logic [7:0] b,
                                         input logic present, input logic first,
                                         input logic last, input logic err);
        t_out_req r;
        r.token_kind    = kind;
        r.value_byte    = b;
        r.byte_present  = present;
        r.token_first   = first;
        r.token_last    = last;
        r.parse_error   = err;
        r.document_done = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/jbt_lexer.sv =====
// ============================================================================
// jbt_lexer
// Lexer state and per-byte decode; produces zero to two results per byte.
// ============================================================================
module jbt_lexer
    import jbt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    output t_push   o_push
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_STRING  = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_KEYWORD = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    logic [2:0] r_mode, n_mode;
    logic       r_quote_single, n_quote_single;
    logic       r_prev_bs, n_prev_bs;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_held_valid, n_held_valid;
    logic       r_held_first, n_held_first;
    logic [1:0] r_kw_id, n_kw_id;
    logic [2:0] r_kw_pos, n_kw_pos;

    logic [7:0] s_b;
    logic [3:0] s_hk;
    logic [1:0] s_kid;
    logic       s_is_space, s_is_digit, s_kw_ok, s_kw_last;
    logic [7:0] s_quote;
    logic       s_idle, s_pass;
    t_out_req   s_res [2];
    logic [1:0] s_cnt;

    assign s_b        = i_req.text_byte;
    assign s_is_space = (s_b == CH_SPACE) || (s_b >= CH_TAB && s_b <= CH_CR);
    assign s_is_digit = (s_b >= CH_ZERO) && (s_b <= CH_NINE);
    assign s_quote    = r_quote_single ? CH_SQUOTE : CH_DQUOTE;
    assign s_kid      = r_kw_id[1] ? KW_NULL : r_kw_id;
    assign s_kw_ok    = (r_kw_pos < kw_len(s_kid)) && (s_b == kw_char(s_kid, r_kw_pos));
    assign s_kw_last  = (r_kw_pos == kw_len(s_kid) - 3'd1);
    assign s_hk       = (r_mode == MODE_NUMBER)  ? KIND_NUMBER :
                        (r_mode == MODE_KEYWORD) ? (s_kid == KW_NULL ? KIND_NULL : KIND_BOOL) :
                                                   KIND_STRING;

    always_comb begin
        n_mode         = r_mode;
        n_quote_single = r_quote_single;
        n_prev_bs      = r_prev_bs;
        n_held_byte    = r_held_byte;
        n_held_valid   = r_held_valid;
        n_held_first   = r_held_first;
        n_kw_id        = r_kw_id;
        n_kw_pos       = r_kw_pos;
        s_res[0]       = '0;
        s_res[1]       = '0;
        s_cnt          = 2'd0;
        s_idle         = 1'b0;
        s_pass         = 1'b0;

        if (i_req.end_of_text) begin
            if (r_mode == MODE_STRING || r_mode == MODE_NUMBER) begin
                if (r_held_valid) begin
                    s_res[0] = jbt_res(s_hk, r_held_byte, 1'b1, r_held_first, 1'b1, 1'b0);
                end else if (r_mode == MODE_STRING) begin
                    s_res[0] = jbt_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                end else begin
                    s_res[0] = jbt_res(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
                end
            end else if (r_mode == MODE_KEYWORD) begin
                s_res[0] = jbt_res(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
                s_res[0] = jbt_res(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
            end
            s_res[0].document_done = 1'b1;
            s_cnt          = 2'd1;
            n_mode         = MODE_IDLE;
            n_quote_single = 1'b0;
            n_prev_bs      = 1'b0;
            n_held_byte    = 8'h00;
            n_held_valid   = 1'b0;
            n_held_first   = 1'b0;
            n_kw_id        = 2'd0;
            n_kw_pos       = 3'd0;
        end else begin
            case (r_mode)
                MODE_STRING: begin
                    if (s_b == s_quote && !r_prev_bs) begin
                        if (r_held_valid) begin
                            s_res[0] = jbt_res(KIND_STRING, r_held_byte, 1'b1, r_held_first,
                                               1'b1, 1'b0);
                        end else begin
                            s_res[0] = jbt_res(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                        end
                        s_cnt        = 2'd1;
                        n_mode       = MODE_IDLE;
                        n_held_valid = 1'b0;
                        n_held_first = 1'b0;
                        n_prev_bs    = 1'b0;
                    end else begin
                        s_pass    = 1'b1;
                        n_prev_bs = (s_b == CH_BACKSLASH);
                    end
                end
                MODE_NUMBER: begin
                    if (s_is_digit || s_b == CH_DOT) begin
                        s_pass = 1'b1;
                    end else begin
                        if (r_held_valid) begin
                            s_res[0] = jbt_res(KIND_NUMBER, r_held_byte, 1'b1, r_held_first,
                                               1'b1, 1'b0);
                            s_cnt    = 2'd1;
                        end
                        n_mode       = MODE_IDLE;
                        n_held_valid = 1'b0;
                        n_held_first = 1'b0;
                        s_idle       = 1'b1;
                    end
                end
                MODE_KEYWORD: begin
                    if (s_kw_ok) begin
                        if (s_kw_last) begin
                            if (r_held_valid) begin
                                s_res[0] = jbt_res(s_hk, r_held_byte, 1'b1, r_held_first,
                                                   1'b0, 1'b0);
                                s_cnt    = 2'd1;
                            end
                            s_res[s_cnt[0]] = jbt_res(s_hk, s_b, 1'b1, !r_held_valid,
                                                      1'b1, 1'b0);
                            s_cnt        = s_cnt + 2'd1;
                            n_mode       = MODE_IDLE;
                            n_held_valid = 1'b0;
                            n_held_first = 1'b0;
                            n_kw_pos     = 3'd0;
                        end else begin
                            s_pass   = 1'b1;
                            n_kw_pos = r_kw_pos + 3'd1;
                        end
                    end else begin
                        s_res[0]     = jbt_res(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                        s_cnt        = 2'd1;
                        n_mode       = MODE_ERROR;
                        n_held_valid = 1'b0;
                        n_held_first = 1'b0;
                    end
                end
                MODE_ERROR: begin
                    n_mode = MODE_ERROR;
                end
                default: begin
                    n_mode = MODE_IDLE;
                    s_idle = 1'b1;
                end
            endcase

            // emit held byte as a middle byte, hold the new one
            if (s_pass) begin
                if (r_held_valid) begin
                    s_res[0] = jbt_res(s_hk, r_held_byte, 1'b1, r_held_first, 1'b0, 1'b0);
                    s_cnt    = 2'd1;
                end
                n_held_byte  = s_b;
                n_held_valid = 1'b1;
                n_held_first = !r_held_valid;
            end

            // byte between tokens
            if (s_idle && !s_is_space) begin
                if (s_b == CH_DQUOTE || s_b == CH_SQUOTE) begin
                    n_mode         = MODE_STRING;
                    n_quote_single = (s_b == CH_SQUOTE);
                    n_prev_bs      = 1'b0;
                    n_held_valid   = 1'b0;
                    n_held_first   = 1'b0;
                end else if (s_b == CH_MINUS || s_is_digit) begin
                    n_mode       = MODE_NUMBER;
                    n_held_byte  = s_b;
                    n_held_valid = 1'b1;
                    n_held_first = 1'b1;
                end else if (s_b == CH_T || s_b == CH_F || s_b == CH_N) begin
                    n_mode       = MODE_KEYWORD;
                    n_kw_id      = (s_b == CH_T) ? KW_TRUE : ((s_b == CH_F) ? KW_FALSE : KW_NULL);
                    n_kw_pos     = 3'd1;
                    n_held_byte  = s_b;
                    n_held_valid = 1'b1;
                    n_held_first = 1'b1;
                end else begin
                    case (s_b)
                        CH_COMMA: s_res[s_cnt[0]] = jbt_res(KIND_COMMA, s_b, 1'b1, 1'b1,
                                                            1'b1, 1'b0);
                        CH_COLON: s_res[s_cnt[0]] = jbt_res(KIND_COLON, s_b, 1'b1, 1'b1,
                                                            1'b1, 1'b0);
                        CH_LBRACE: s_res[s_cnt[0]] = jbt_res(KIND_BRACE_O, s_b, 1'b1, 1'b1,
                                                             1'b1, 1'b0);
                        CH_RBRACE: s_res[s_cnt[0]] = jbt_res(KIND_BRACE_C, s_b, 1'b1, 1'b1,
                                                             1'b1, 1'b0);
                        CH_LBRACKET: s_res[s_cnt[0]] = jbt_res(KIND_BRACKET_O, s_b, 1'b1,
                                                               1'b1, 1'b1, 1'b0);
                        CH_RBRACKET: s_res[s_cnt[0]] = jbt_res(KIND_BRACKET_C, s_b, 1'b1,
                                                               1'b1, 1'b1, 1'b0);
                        default: begin
                            s_res[s_cnt[0]] = jbt_res(KIND_STRING, 8'h00, 1'b0, 1'b0,
                                                      1'b0, 1'b1);
                            n_mode          = MODE_ERROR;
                            n_held_valid    = 1'b0;
                            n_held_first    = 1'b0;
                        end
                    endcase
                    s_cnt = s_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_quote_single <= 1'b0;
            r_prev_bs      <= 1'b0;
            r_held_byte    <= 8'h00;
            r_held_valid   <= 1'b0;
            r_held_first   <= 1'b0;
            r_kw_id        <= 2'd0;
            r_kw_pos       <= 3'd0;
        end else if (i_accept) begin
            r_mode         <= n_mode;
            r_quote_single <= n_quote_single;
            r_prev_bs      <= n_prev_bs;
            r_held_byte    <= n_held_byte;
            r_held_valid   <= n_held_valid;
            r_held_first   <= n_held_first;
            r_kw_id        <= n_kw_id;
            r_kw_pos       <= n_kw_pos;
        end
    end

    assign o_push.cnt  = i_accept ? s_cnt : 2'd0;
    assign o_push.res0 = s_res[0];
    assign o_push.res1 = s_res[1];

endmodule

// ===== sv/jbt_out_fifo.sv =====
// ============================================================================
// jbt_out_fifo
// Small result queue: two writes, one read per cycle.
// ============================================================================
module jbt_out_fifo
    import jbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_push    i_push,
    output logic     o_room,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_data
);

    t_out_req             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 s_pop;

    assign s_pop   = o_valid && i_ready;
    assign n_wr    = r_wr + FIFO_AW'(i_push.cnt);
    assign n_rd    = r_rd + FIFO_AW'(s_pop);
    assign n_count = r_count + FIFO_CW'(i_push.cnt) - FIFO_CW'(s_pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // room for a worst-case byte (two results)
    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== sv/json_byte_tokenizer.sv =====
// ============================================================================
// json_byte_tokenizer: results are registered in the result queue before they reach the output.
// Throughput: one byte per cycle while the queue has room for two results; a
// byte that yields two results (a number closed by punctuation, the last letter
// of a keyword) leaves them one after another from the single-read result queue.
// Reset: synchronous active-low i_rst_n clears lexer state and empties the queue.
// ============================================================================
module json_byte_tokenizer
    import jbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // input request channel
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_data,
    // result request channel
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_data
);

    // Accept a byte whenever the queue can take two more results; the lexer
    // decodes it against its state in the same cycle and the results land in
    // the queue registers at the edge, so the two sides are decoupled.
    logic  s_accept;
    t_push s_push;

    assign s_accept = i_in_valid && o_in_ready;

    // Lexer: mode, quote, backslash, held byte and keyword position.
    // One byte is held back so the final byte of a token can carry token_last.
    jbt_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_req    (i_in_data),
        .o_push   (s_push)
    );

    // Result queue: absorbs 0..2 results per byte, drains one a cycle while i_out_ready.
    jbt_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // End of document always yields exactly one result, flagged done
    a_end_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_in_data.end_of_text) |->
            (s_push.cnt == 2'd1 && s_push.res0.document_done))
        else $error("end item did not give a single done result");

    // Nothing is pushed without an accepted byte
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_accept |-> (s_push.cnt == 2'd0))
        else $error("result pushed without an accepted byte");

    // Back-pressure only while results are waiting
    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty result queue");

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== tb/sv/json_byte_tokenizer_test.sv =====
// ============================================================================
// json_byte_tokenizer_test
// Self-checking bench for the streaming JSON lexer. A short table of directed
// bytes is followed by random documents (mostly well formed, some broken or
// pure noise). Every accepted input request goes through a local lexer model;
// its results (for typed table rows, the table's own result) are queued, and
// every result request taken from the block is matched against the oldest one.
// ============================================================================
module json_byte_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jbt_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int DRAIN_CYCLES   = 20;    // leave margin after the queue drains
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving
    localparam int MAX_REPORTS    = 40;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT hookup. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in_req  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_req out_data;

    always #(CLK_PERIOD / 2) clk = ~clk;

    json_byte_tokenizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Lexer model: own copy of the lexer state, updated once per accepted
    // input request. lex_out holds the results of the latest request.
    // ------------------------------------------------------------------------
    typedef enum logic [2:0] {
        LX_IDLE,
        LX_STRING,
        LX_NUMBER,
        LX_KEYWORD,
        LX_ERROR
    } t_lex_mode;

    t_lex_mode  lx_mode;
    logic       quote_single;
    logic       after_backslash;
    logic [7:0] hold_byte;
    logic       hold_valid;
    logic       hold_first;
    logic [1:0] kw_sel;
    logic [2:0] kw_idx;
    t_out_req   lex_out[$];

    // indexed by KW_TRUE / KW_FALSE / KW_NULL
    string kw_words [3] = '{"true", "false", "null"};

    logic [7:0] punct_chars [6] = '{CH_COMMA, CH_COLON, CH_LBRACE,
                                    CH_RBRACE, CH_LBRACKET, CH_RBRACKET};

    t_out_req token_exp_q[$];   // results still owed by the block
    t_in_req  text_q[$];        // bytes of the document being composed
    int       fail_count  = 0;
    int       text_items  = 0;  // random requests sent
    int       burst_left  = 0;
    int       quiet_cycles = 0;

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // kind of the byte being held back
    function automatic logic [3:0] hold_kind();
        if (lx_mode == LX_NUMBER) return KIND_NUMBER;
        if (lx_mode == LX_KEYWORD) return (kw_sel == KW_NULL) ? KIND_NULL : KIND_BOOL;
        return KIND_STRING;
    endfunction

    task automatic lex_emit(input logic [3:0] kind, input logic [7:0] b,
                            input logic present, input logic first,
                            input logic last, input logic err);
        t_out_req r;
        r = '{kind, b, present, first, last, err, 1'b0};
        lex_out.insert(lex_out.size(), r);
    endtask

    task automatic lex_clear();
        lx_mode         = LX_IDLE;
        quote_single    = 1'b0;
        after_backslash = 1'b0;
        hold_byte       = 8'h00;
        hold_valid      = 1'b0;
        hold_first      = 1'b0;
        kw_sel          = KW_TRUE;
        kw_idx          = 3'd0;
    endtask

    // release the held byte as a middle byte, keep b back instead
    task automatic shift_in(input logic [7:0] b);
        if (hold_valid) lex_emit(hold_kind(), hold_byte, 1'b1, hold_first, 1'b0, 1'b0);
        hold_first = !hold_valid;
        hold_byte  = b;
        hold_valid = 1'b1;
    endtask

    task automatic lex_fail();
        lx_mode    = LX_ERROR;
        hold_valid = 1'b0;
        hold_first = 1'b0;
        lex_emit(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
    endtask

    // byte seen between tokens
    task automatic lex_idle(input logic [7:0] b);
        logic [3:0] kind;
        if (is_ws(b)) return;
        if (b == CH_DQUOTE || b == CH_SQUOTE) begin
            lx_mode         = LX_STRING;
            quote_single    = (b == CH_SQUOTE);
            after_backslash = 1'b0;
            hold_valid      = 1'b0;
            hold_first      = 1'b0;
            return;
        end
        if (b == CH_MINUS || is_digit(b)) begin
            lx_mode    = LX_NUMBER;
            hold_byte  = b;
            hold_valid = 1'b1;
            hold_first = 1'b1;
            return;
        end
        if (b == CH_T || b == CH_F || b == CH_N) begin
            lx_mode    = LX_KEYWORD;
            kw_sel     = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
            kw_idx     = 3'd1;
            hold_byte  = b;
            hold_valid = 1'b1;
            hold_first = 1'b1;
            return;
        end
        case (b)
            CH_COMMA:    kind = KIND_COMMA;
            CH_COLON:    kind = KIND_COLON;
            CH_LBRACE:   kind = KIND_BRACE_O;
            CH_RBRACE:   kind = KIND_BRACE_C;
            CH_LBRACKET: kind = KIND_BRACKET_O;
            CH_RBRACKET: kind = KIND_BRACKET_C;
            default: begin
                lex_fail();
                return;
            end
        endcase
        lex_emit(kind, b, 1'b1, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic lex_predict(input t_in_req r);
        logic [7:0] b;
        logic [7:0] quote;
        string      word;
        lex_out.delete();
        b = r.text_byte;
        if (r.end_of_text) begin
            // flush whatever is open, mark the final result, back to reset
            if (lx_mode == LX_STRING || lx_mode == LX_NUMBER) begin
                if (hold_valid)
                    lex_emit(hold_kind(), hold_byte, 1'b1, hold_first, 1'b1, 1'b0);
                else if (lx_mode == LX_STRING)
                    lex_emit(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                else
                    lex_emit(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
            end else if (lx_mode == LX_KEYWORD) begin
                lex_emit(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
                lex_emit(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
            end
            lex_out[lex_out.size() - 1].document_done = 1'b1;
            lex_clear();
            return;
        end
        case (lx_mode)
            LX_STRING: begin
                quote = quote_single ? CH_SQUOTE : CH_DQUOTE;
                if (b == quote && !after_backslash) begin
                    if (hold_valid)
                        lex_emit(KIND_STRING, hold_byte, 1'b1, hold_first, 1'b1, 1'b0);
                    else
                        lex_emit(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                    lx_mode         = LX_IDLE;
                    hold_valid      = 1'b0;
                    hold_first      = 1'b0;
                    after_backslash = 1'b0;
                end else begin
                    shift_in(b);
                    after_backslash = (b == CH_BACKSLASH);
                end
            end
            LX_NUMBER: begin
                if (is_digit(b) || b == CH_DOT) begin
                    shift_in(b);
                end else begin
                    // number closes, then the byte is taken as between tokens
                    if (hold_valid)
                        lex_emit(KIND_NUMBER, hold_byte, 1'b1, hold_first, 1'b1, 1'b0);
                    lx_mode    = LX_IDLE;
                    hold_valid = 1'b0;
                    hold_first = 1'b0;
                    lex_idle(b);
                end
            end
            LX_KEYWORD: begin
                word = kw_words[kw_sel];
                if (kw_idx < word.len() && b == word[kw_idx]) begin
                    if (kw_idx + 1 == word.len()) begin
                        if (hold_valid)
                            lex_emit(hold_kind(), hold_byte, 1'b1, hold_first, 1'b0, 1'b0);
                        lex_emit(hold_kind(), b, 1'b1, !hold_valid, 1'b1, 1'b0);
                        lx_mode    = LX_IDLE;
                        hold_valid = 1'b0;
                        hold_first = 1'b0;
                        kw_idx     = 3'd0;
                    end else begin
                        shift_in(b);
                        kw_idx = kw_idx + 3'd1;
                    end
                end else begin
                    lex_fail();
                end
            end
            LX_ERROR: ;  // swallow everything until end of document
            default: lex_idle(b);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Rows with typed = 1 carry their result (or none);
    // the rest are checked against the lexer model.
    // ------------------------------------------------------------------------
    typedef struct packed {
        t_in_req  req;
        logic     typed;
        logic     has_res;
        t_out_req res;
    } t_dir_row;

    localparam t_out_req NO_TOKEN     = '0;
    localparam t_out_req DOC_STATUS   = '{KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam t_out_req LEX_ERROR    = '{KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam t_out_req EMPTY_STR    = '{KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam t_out_req OPEN_STR_END = '{KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam t_out_req TOK_LBRACE   = '{KIND_BRACE_O, CH_LBRACE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam t_out_req TOK_RBRACE   = '{KIND_BRACE_C, CH_RBRACE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam t_out_req TOK_COLON    = '{KIND_COLON, CH_COLON, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    localparam t_out_req TOK_COMMA    = '{KIND_COMMA, CH_COMMA, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

    localparam t_dir_row DIR_ROWS [0:27] = '{
        '{'{8'h00, 1'b1},        1'b1, 1'b1, DOC_STATUS},    // end straight after reset
        '{'{CH_LBRACE, 1'b0},    1'b1, 1'b1, TOK_LBRACE},
        '{'{CH_DQUOTE, 1'b0},    1'b1, 1'b0, NO_TOKEN},
        '{'{CH_DQUOTE, 1'b0},    1'b1, 1'b1, EMPTY_STR},     // empty string
        '{'{CH_COLON, 1'b0},     1'b1, 1'b1, TOK_COLON},
        '{'{CH_SQUOTE, 1'b0},    1'b0, 1'b0, NO_TOKEN},      // single-quoted string
        '{'{CH_BACKSLASH, 1'b0}, 1'b0, 1'b0, NO_TOKEN},
        '{'{CH_SQUOTE, 1'b0},    1'b0, 1'b0, NO_TOKEN},      // escaped, stays inside
        '{'{CH_SQUOTE, 1'b0},    1'b0, 1'b0, NO_TOKEN},      // closes
        '{'{CH_COMMA, 1'b0},     1'b1, 1'b1, TOK_COMMA},
        '{'{CH_MINUS, 1'b0},     1'b0, 1'b0, NO_TOKEN},
        '{'{CH_DOT, 1'b0},       1'b0, 1'b0, NO_TOKEN},
        '{'{CH_RBRACKET, 1'b0},  1'b0, 1'b0, NO_TOKEN},      // number end plus bracket
        '{'{CH_N, 1'b0},         1'b0, 1'b0, NO_TOKEN},
        '{'{"u", 1'b0},          1'b0, 1'b0, NO_TOKEN},
        '{'{"l", 1'b0},          1'b0, 1'b0, NO_TOKEN},
        '{'{"l", 1'b0},          1'b0, 1'b0, NO_TOKEN},      // keyword done, two bytes
        '{'{CH_NINE, 1'b0},      1'b0, 1'b0, NO_TOKEN},
        '{'{CH_SPACE, 1'b0},     1'b0, 1'b0, NO_TOKEN},      // whitespace ends number
        '{'{CH_T, 1'b0},         1'b0, 1'b0, NO_TOKEN},
        '{'{CH_TAB, 1'b0},       1'b1, 1'b1, LEX_ERROR},     // whitespace in keyword
        '{'{8'hFF, 1'b0},        1'b1, 1'b0, NO_TOKEN},      // ignored after error
        '{'{8'hFF, 1'b1},        1'b1, 1'b1, DOC_STATUS},
        '{'{CH_RBRACE, 1'b0},    1'b1, 1'b1, TOK_RBRACE},
        '{'{CH_DQUOTE, 1'b0},    1'b1, 1'b0, NO_TOKEN},
        '{'{8'h55, 1'b1},        1'b1, 1'b1, OPEN_STR_END},  // unterminated string
        '{'{8'hFF, 1'b0},        1'b1, 1'b1, LEX_ERROR},     // unexpected byte
        '{'{8'h00, 1'b1},        1'b1, 1'b1, DOC_STATUS}
    };

    // ------------------------------------------------------------------------
    // Document composer for the random part
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        t_in_req r;
        r.text_byte   = b;
        r.end_of_text = 1'b0;
        text_q.insert(text_q.size(), r);
    endtask

    task automatic add_end();
        t_in_req r;
        r.text_byte   = 8'($urandom_range(0, 255));  // don't-care byte
        r.end_of_text = 1'b1;
        text_q.insert(text_q.size(), r);
    endtask

    task automatic add_gap_space();
        int n;
        int k;
        int sel;
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 5);
            add_byte(sel == 5 ? CH_SPACE : CH_TAB + sel[7:0]);
        end
    endtask

    // cut: stop before the closing quote
    task automatic add_string(input bit cut);
        logic [7:0] quote;
        logic [7:0] c;
        logic [7:0] last;
        int         len;
        int         k;
        quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        add_byte(quote);
        last = quote;
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
        for (k = 0; k < len; k++) begin
            c = 8'($urandom_range(0, 255));
            if (c == quote) add_byte(CH_BACKSLASH);
            add_byte(c);
            last = c;
        end
        if (cut) return;
        if (last == CH_BACKSLASH) add_byte("a");  // keep the close quote live
        add_byte(quote);
    endtask

    task automatic add_number();
        int n;
        int k;
        if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
            add_byte($urandom_range(0, 5) == 0 ? CH_DOT : CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // flaw 0: whole word, 1: wrong byte part way, 2: cut part way
    task automatic add_keyword(input int flaw);
        string      word;
        int         keep;
        int         k;
        logic [7:0] b;
        word = kw_words[$urandom_range(0, 2)];
        keep = (flaw == 0) ? word.len() : $urandom_range(1, word.len() - 1);
        for (k = 0; k < keep; k++) add_byte(word[k]);
        if (flaw == 1) begin
            b = 8'($urandom_range(0, 255));
            if (b == word[keep]) b = CH_SPACE;
            add_byte(b);
        end
    endtask

    task automatic add_token();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) add_byte(punct_chars[$urandom_range(0, 5)]);
        else if (sel < 6) add_string(1'b0);
        else if (sel < 8) add_number();
        else add_keyword(0);
    endtask

    // mostly clean documents, some with one flaw, a few pure noise
    task automatic compose_document();
        int style;
        int ntok;
        int flaw_at;
        int k;
        bit cut;
        style   = $urandom_range(0, 19);
        ntok    = $urandom_range(1, 14);
        flaw_at = $urandom_range(0, ntok - 1);
        cut     = 1'b0;
        for (k = 0; k < ntok && !cut; k++) begin
            add_gap_space();
            if (style == 19) begin
                add_byte(8'($urandom_range(0, 255)));
            end else if (style >= 16 && k == flaw_at) begin
                case ($urandom_range(0, 3))
                    0: add_byte(8'($urandom_range(0, 255)));
                    1: add_keyword(1);
                    2: begin
                        add_string(1'b1);
                        cut = 1'b1;
                    end
                    default: begin
                        add_keyword(2);
                        cut = 1'b1;
                    end
                endcase
            end else begin
                add_token();
            end
        end
        if (!cut) add_gap_space();
        add_end();
    endtask

    // ------------------------------------------------------------------------
    // Input side: bursts of random length, random gaps between them.
    // Returns in the time step of the edge that accepted the request.
    // ------------------------------------------------------------------------
    task automatic send_text(input t_in_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop valid and wait for every owed result to come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (token_exp_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready follows a stall style that changes every so often
    // ------------------------------------------------------------------------
    int rx_style = 0;
    int rx_left  = 0;
    int rx_tick  = 0;

    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left  <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0: out_ready <= 1'b1;                              // no stalls
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);       // heavy backpressure
            default: out_ready <= (rx_tick % 3 != 0);          // fixed beat
        endcase
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    t_out_req want_tok;

    task automatic check_token(input t_out_req want, input t_out_req got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result expected %h got %h", $time, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (token_exp_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result expected none got %h", $time, out_data);
            end else begin
                want_tok = token_exp_q.pop_front();
                check_token(want_tok, out_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no request moving on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles, %0d results owed",
                     $time, quiet_cycles, token_exp_q.size());
            $display("json_byte_tokenizer verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_in_req req;
        int      i;
        lex_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (i = 0; i < $size(DIR_ROWS); i++) begin
            send_text(DIR_ROWS[i].req);
            lex_predict(DIR_ROWS[i].req);
            if (DIR_ROWS[i].typed) begin
                if (DIR_ROWS[i].has_res)
                    token_exp_q.insert(token_exp_q.size(), DIR_ROWS[i].res);
            end else begin
                foreach (lex_out[k]) token_exp_q.insert(token_exp_q.size(), lex_out[k]);
            end
        end
        hold_until_drained();

        // random documents
        while (text_items < RANDOM_ITEMS) begin
            compose_document();
            while (text_q.size() != 0) begin
                req = text_q.pop_front();
                send_text(req);
                text_items++;
                lex_predict(req);
                foreach (lex_out[k]) token_exp_q.insert(token_exp_q.size(), lex_out[k]);
            end
            if ($urandom_range(0, 9) == 0) hold_until_drained();
        end
        in_valid <= 1'b0;

        // let the owed results drain, then watch for strays
        while (token_exp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("json_byte_tokenizer verification clean");
        else
            $display("json_byte_tokenizer verification failed");
        $finish;
    end

endmodule

// ===== json_byte_tokenizer.f =====
sv/jbt_pkg.sv
sv/jbt_lexer.sv
sv/jbt_out_fifo.sv
sv/json_byte_tokenizer.sv
tb/sv/json_byte_tokenizer_test.sv
